// ===== design/pdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pdc_pkg;

	localparam int LOOPS          = 2;
	localparam int MEAS_WIDTH     = 24;
	localparam int GAIN_FRAC_BITS = 16;

	localparam int GAIN_W    = 32;
	localparam int OUT_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	localparam int IDX_W  = (LOOPS > 1) ? $clog2(LOOPS) : 1;
	localparam int DIFF_W = MEAS_WIDTH + 1;
	localparam int PROD_W = GAIN_W + DIFF_W;
	localparam int INT_W  = OUT_W + GAIN_FRAC_BITS;
	localparam int PD_W   = PROD_W + 1;
	localparam int VAL_W  = PROD_W + 2;

	// Differences saturate to +-2^30 before they reach the multipliers.
	localparam int DIFF_LIMIT_LOG = 30;

	localparam logic [OUT_W-1:0] OUT_MIN_RST = 8'd100;
	localparam logic [OUT_W-1:0] OUT_MAX_RST = 8'd255;

	localparam logic CMD_COMPUTE = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP,
		REG_KI,
		REG_KD,
		REG_OUT_MIN,
		REG_OUT_MAX
	} cfg_reg_t;

	typedef logic [IDX_W-1:0] loop_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic [OUT_W-1:0]  out_min;
		logic [OUT_W-1:0]  out_max;
	} cfg_t;

	typedef struct packed {
		logic                  en;
		loop_idx_t             addr;
		logic [MEAS_WIDTH-1:0] data;
	} prev_wr_t;

	typedef struct packed {
		logic             en;
		loop_idx_t        addr;
		logic [INT_W-1:0] data;
	} int_wr_t;

	function automatic loop_idx_t chan_index(input logic ch);
		return IDX_W'({31'd0, ch} % LOOPS);
	endfunction

	function automatic logic signed [DIFF_W-1:0] sat_diff(input logic signed [DIFF_W-1:0] d);
		logic signed [63:0] w;
		logic signed [63:0] lim;
		w   = {{(64-DIFF_W){d[DIFF_W-1]}}, d};
		lim = 64'sd1 <<< DIFF_LIMIT_LOG;
		if (w > lim) begin
			w = lim;
		end else if (w < -lim) begin
			w = -lim;
		end
		return w[DIFF_W-1:0];
	endfunction

	// Above the upper bound wins first, so an inverted pair of bounds still
	// yields either bound.
	function automatic logic [INT_W-1:0] clamp_q(input logic signed [VAL_W-1:0] v,
			input logic [OUT_W-1:0] lo_int, input logic [OUT_W-1:0] hi_int);
		logic signed [VAL_W-1:0] hi;
		logic signed [VAL_W-1:0] lo;
		hi = {{(VAL_W-INT_W){1'b0}}, hi_int, {GAIN_FRAC_BITS{1'b0}}};
		lo = {{(VAL_W-INT_W){1'b0}}, lo_int, {GAIN_FRAC_BITS{1'b0}}};
		if (v > hi) begin
			return hi[INT_W-1:0];
		end else if (v < lo) begin
			return lo[INT_W-1:0];
		end
		return v[INT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== design/pdc_config.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdc_config (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pdc_pkg::CFG_W-1:0]      cfg_data,
	output pdc_pkg::cfg_t                       cfg
);

	pdc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp      <= '0;
			cfg_q.ki      <= '0;
			cfg_q.kd      <= '0;
			cfg_q.out_min <= pdc_pkg::OUT_MIN_RST;
			cfg_q.out_max <= pdc_pkg::OUT_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdc_pkg::REG_KP:      cfg_q.kp      <= cfg_data[pdc_pkg::GAIN_W-1:0];
				pdc_pkg::REG_KI:      cfg_q.ki      <= cfg_data[pdc_pkg::GAIN_W-1:0];
				pdc_pkg::REG_KD:      cfg_q.kd      <= cfg_data[pdc_pkg::GAIN_W-1:0];
				pdc_pkg::REG_OUT_MIN: cfg_q.out_min <= cfg_data[pdc_pkg::OUT_W-1:0];
				pdc_pkg::REG_OUT_MAX: cfg_q.out_max <= cfg_data[pdc_pkg::OUT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== design/pdc_state_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdc_state_mem (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                rd_en,
	input  wire pdc_pkg::loop_idx_t                  rd_addr,
	input  wire pdc_pkg::prev_wr_t                   prev_wr,
	input  wire pdc_pkg::int_wr_t                    int_wr,
	output logic [pdc_pkg::MEAS_WIDTH-1:0]           prev_rd,
	output logic [pdc_pkg::INT_W-1:0]                int_rd
);

	logic [pdc_pkg::MEAS_WIDTH-1:0] prev_mem [pdc_pkg::LOOPS];
	logic [pdc_pkg::INT_W-1:0]      int_mem  [pdc_pkg::LOOPS];

	logic [pdc_pkg::LOOPS-1:0]      prev_vld_q;
	logic [pdc_pkg::LOOPS-1:0]      int_vld_q;
	logic                           prev_rdv_q;
	logic                           int_rdv_q;
	logic [pdc_pkg::MEAS_WIDTH-1:0] prev_rd_q;
	logic [pdc_pkg::INT_W-1:0]      int_rd_q;

	always_ff @(posedge clk) begin
		if (prev_wr.en) begin
			prev_mem[prev_wr.addr] <= prev_wr.data;
		end
		if (int_wr.en) begin
			int_mem[int_wr.addr] <= int_wr.data;
		end
		if (rd_en) begin
			prev_rd_q <= prev_mem[rd_addr];
			int_rd_q  <= int_mem[rd_addr];
		end
	end

	// An entry that was never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_vld_q <= '0;
			int_vld_q  <= '0;
			prev_rdv_q <= 1'b0;
			int_rdv_q  <= 1'b0;
		end else begin
			if (prev_wr.en) begin
				prev_vld_q[prev_wr.addr] <= 1'b1;
			end
			if (int_wr.en) begin
				int_vld_q[int_wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				prev_rdv_q <= prev_vld_q[rd_addr];
				int_rdv_q  <= int_vld_q[rd_addr];
			end
		end
	end

	assign prev_rd = prev_rdv_q ? prev_rd_q : '0;
	assign int_rd  = int_rdv_q ? int_rd_q : '0;

endmodule

`default_nettype wire

// ===== design/pid_drive_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-loop PID drive controller.
// Input channel (in_valid/in_ready): cmd, channel, measured, setpoint. A compute
// command updates the loop's clamped integrator and returns the clamped drive;
// a clear command zeroes the loop's integrator and last measured value and
// returns out_min. Output channel (out_valid/out_ready): drive and loop_id,
// one result per input transfer, in input order.
// Configuration: kp, ki, kd, out_min, out_max are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while no item is in flight, which the block itself does not enforce.
// out_valid rises once the item has left stage 4 for the output register. The
// pipeline takes one item per cycle unless it is full and the receiver stalls;
// the integrator read-modify-write loop is closed by forwarding
// the write port of the state memory into the stages behind it.
// While the receiver stalls, the five stages keep filling; in_ready drops only
// when all of them hold an item.
// Reset clears the registers to kp = ki = kd = 0, out_min = 100, out_max = 255,
// and marks both state memories empty so every loop starts from zero.
module pid_drive_controller (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [pdc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [pdc_pkg::CFG_W-1:0]             cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  cmd,
	input  wire logic                                  channel,
	input  wire logic signed [pdc_pkg::MEAS_WIDTH-1:0] measured,
	input  wire logic signed [pdc_pkg::MEAS_WIDTH-1:0] setpoint,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [pdc_pkg::OUT_W-1:0]                  drive,
	output logic                                       loop_id
);

	localparam int MW = pdc_pkg::MEAS_WIDTH;
	localparam int DW = pdc_pkg::DIFF_W;
	localparam int PW = pdc_pkg::PROD_W;
	localparam int IW = pdc_pkg::INT_W;
	localparam int QW = pdc_pkg::PD_W;
	localparam int VW = pdc_pkg::VAL_W;
	localparam int FB = pdc_pkg::GAIN_FRAC_BITS;

	pdc_pkg::cfg_t      cfg;
	pdc_pkg::prev_wr_t  prev_wr;
	pdc_pkg::int_wr_t   int_wr;
	pdc_pkg::loop_idx_t idx_in;
	logic [MW-1:0]      prev_rd;
	logic [IW-1:0]      int_rd;

	logic en1, en2, en3, en4, en_o, acc_in;

	// Stage 1: memory read data arrives.
	logic               vld_s1;
	logic               cmd_s1;
	logic               ch_s1;
	pdc_pkg::loop_idx_t idx_s1;
	logic signed [MW-1:0] meas_s1;
	logic signed [MW-1:0] setp_s1;
	logic               pfwd_v_s1;
	logic [MW-1:0]      pfwd_s1;
	logic               ifwd_v_s1;
	logic [IW-1:0]      ifwd_s1;

	// Stage 2: differences.
	logic               vld_s2;
	logic               cmd_s2;
	logic               ch_s2;
	pdc_pkg::loop_idx_t idx_s2;
	logic signed [DW-1:0] err_s2;
	logic signed [DW-1:0] dm_s2;
	logic [IW-1:0]      int_s2;

	// Stage 3: products; the integrator is written back at its exit.
	logic               vld_s3;
	logic               cmd_s3;
	logic               ch_s3;
	pdc_pkg::loop_idx_t idx_s3;
	logic signed [PW-1:0] pi_s3;
	logic signed [PW-1:0] pp_s3;
	logic signed [PW-1:0] pd_s3;
	logic [IW-1:0]      int_s3;

	// Stage 4: clamped integrator and the P minus D sum.
	logic               vld_s4;
	logic               cmd_s4;
	logic               ch_s4;
	logic [IW-1:0]      acc_s4;
	logic signed [QW-1:0] ppd_s4;

	logic               out_vld_q;
	logic [pdc_pkg::OUT_W-1:0] drive_q;
	logic               loop_q;

	logic [MW-1:0]      prev_eff;
	logic [IW-1:0]      int_eff;
	logic signed [DW-1:0] err_raw, dm_raw;
	logic signed [PW-1:0] pi_c, pp_c, pd_c;
	logic signed [VW-1:0] acc_sum;
	logic [IW-1:0]      acc_c;
	logic signed [QW-1:0] ppd_c;
	logic signed [VW-1:0] val_sum;
	logic [IW-1:0]      val_c;
	logic [pdc_pkg::OUT_W-1:0] drive_c;

	pdc_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pdc_state_mem u_state_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc_in),
		.rd_addr (idx_in),
		.prev_wr (prev_wr),
		.int_wr  (int_wr),
		.prev_rd (prev_rd),
		.int_rd  (int_rd)
	);

	// Each stage moves when the one after it is empty or moving.
	assign en_o     = !out_vld_q || out_ready;
	assign en4      = !vld_s4 || en_o;
	assign en3      = !vld_s3 || en4;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;
	assign acc_in   = in_valid && en1;
	assign idx_in   = pdc_pkg::chan_index(channel);

	// Write ports: last measured leaves stage 1, the integrator leaves stage 3.
	always_comb begin
		prev_wr.en   = vld_s1 && en2;
		prev_wr.addr = idx_s1;
		prev_wr.data = (cmd_s1 == pdc_pkg::CMD_CLEAR) ? '0 : meas_s1;
		int_wr.en    = vld_s3 && en4;
		int_wr.addr  = idx_s3;
		int_wr.data  = (cmd_s3 == pdc_pkg::CMD_CLEAR) ? '0 : acc_c;
	end

	// The read port returns the old value on a same-cycle write, so a write
	// at the read edge is captured in stage 1 and wins over the read data.
	always_comb begin
		prev_eff = pfwd_v_s1 ? pfwd_s1 : prev_rd;
		int_eff  = ifwd_v_s1 ? ifwd_s1 : int_rd;
		err_raw  = setp_s1 - meas_s1;
		dm_raw   = meas_s1 - $signed(prev_eff);
	end

	always_comb begin
		pi_c = $signed(cfg.ki) * err_s2;
		pp_c = $signed(cfg.kp) * err_s2;
		pd_c = $signed(cfg.kd) * dm_s2;
	end

	always_comb begin
		acc_sum = $signed({{(VW-IW){1'b0}}, int_s3}) + $signed({{(VW-PW){pi_s3[PW-1]}}, pi_s3});
		acc_c   = pdc_pkg::clamp_q(acc_sum, cfg.out_min, cfg.out_max);
		ppd_c   = pp_s3 - pd_s3;
	end

	always_comb begin
		val_sum = $signed({{(VW-QW){ppd_s4[QW-1]}}, ppd_s4}) + $signed({{(VW-IW){1'b0}}, acc_s4});
		val_c   = pdc_pkg::clamp_q(val_sum, cfg.out_min, cfg.out_max);
		drive_c = (cmd_s4 == pdc_pkg::CMD_CLEAR) ? cfg.out_min : val_c[IW-1:FB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= in_valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
			if (en3) begin
				vld_s3 <= vld_s2;
			end
			if (en4) begin
				vld_s4 <= vld_s3;
			end
			if (en_o) begin
				out_vld_q <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			cmd_s1    <= cmd;
			ch_s1     <= channel;
			idx_s1    <= idx_in;
			meas_s1   <= measured;
			setp_s1   <= setpoint;
			pfwd_v_s1 <= prev_wr.en && (prev_wr.addr == idx_in);
			pfwd_s1   <= prev_wr.data;
			ifwd_v_s1 <= int_wr.en && (int_wr.addr == idx_in);
			ifwd_s1   <= int_wr.data;
		end
		if (vld_s1 && en2) begin
			cmd_s2 <= cmd_s1;
			ch_s2  <= ch_s1;
			idx_s2 <= idx_s1;
			err_s2 <= pdc_pkg::sat_diff(err_raw);
			dm_s2  <= pdc_pkg::sat_diff(dm_raw);
			int_s2 <= (int_wr.en && (int_wr.addr == idx_s1)) ? int_wr.data : int_eff;
		end
		if (vld_s2 && en3) begin
			cmd_s3 <= cmd_s2;
			ch_s3  <= ch_s2;
			idx_s3 <= idx_s2;
			pi_s3  <= pi_c;
			pp_s3  <= pp_c;
			pd_s3  <= pd_c;
			int_s3 <= (int_wr.en && (int_wr.addr == idx_s2)) ? int_wr.data : int_s2;
		end
		if (vld_s3 && en4) begin
			cmd_s4 <= cmd_s3;
			ch_s4  <= ch_s3;
			acc_s4 <= acc_c;
			ppd_s4 <= ppd_c;
		end
		if (vld_s4 && en_o) begin
			drive_q <= drive_c;
			loop_q  <= ch_s4;
		end
	end

	assign out_valid = out_vld_q;
	assign drive     = drive_q;
	assign loop_id   = loop_q;

	// Forwarding relies on no integrator write while an item waits in stage 1 or 2.
	a_s1_hold_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !en2) |-> !int_wr.en)
		else $error("integrator written while stage 1 is held");

	a_s2_hold_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !en3) |-> !int_wr.en)
		else $error("integrator written while stage 2 is held");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && out_vld_q))
		else $error("input blocked with a free pipeline stage");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int STEPS_PER_PHASE = 112;

	typedef struct {
		logic                  op;
		logic                  ch;
		logic signed [pdc_pkg::MEAS_WIDTH-1:0] meas;
		logic signed [pdc_pkg::MEAS_WIDTH-1:0] setp;
	} loop_step_t;

	typedef struct {
		logic [pdc_pkg::OUT_W-1:0] drive;
		logic             loop_id;
	} drive_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pdc_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = pdc_pkg::CMD_COMPUTE;
	logic channel = 1'b0;
	logic signed [pdc_pkg::MEAS_WIDTH-1:0] measured = '0;
	logic signed [pdc_pkg::MEAS_WIDTH-1:0] setpoint = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [pdc_pkg::OUT_W-1:0] drive;
	logic loop_id;

	pid_drive_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.channel   (channel),
		.measured  (measured),
		.setpoint  (setpoint),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive),
		.loop_id   (loop_id)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Local copy of the controller's registers and per-loop state.
	logic signed [pdc_pkg::GAIN_W-1:0] kp_gain = '0;
	logic signed [pdc_pkg::GAIN_W-1:0] ki_gain = '0;
	logic signed [pdc_pkg::GAIN_W-1:0] kd_gain = '0;
	logic [pdc_pkg::OUT_W-1:0] lo_bound = pdc_pkg::OUT_MIN_RST;
	logic [pdc_pkg::OUT_W-1:0] hi_bound = pdc_pkg::OUT_MAX_RST;
	longint integ [pdc_pkg::LOOPS];
	longint last_meas [pdc_pkg::LOOPS];

	loop_step_t step_q [$];
	drive_res_t drive_q [$];
	loop_step_t cur_step;
	drive_res_t want;

	int n_queued = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_fail = 0;
	int n_clears = 0;
	int n_cfg_writes = 0;
	int n_stalls_in = 0;
	int n_cycles = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit quiet = 1'b0;
	int walk_sp [2];
	int walk_meas [2];

	function automatic longint limit_diff(input longint d);
		longint lim;
		lim = longint'(1) <<< 30;
		if (d > lim)
			return lim;
		if (d < -lim)
			return -lim;
		return d;
	endfunction

	function automatic longint clamp_bounds(input longint v);
		longint hi;
		longint lo;
		hi = longint'(hi_bound) <<< pdc_pkg::GAIN_FRAC_BITS;
		lo = longint'(lo_bound) <<< pdc_pkg::GAIN_FRAC_BITS;
		// The upper bound is checked first, so inverted bounds give one or the other.
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic drive_res_t pid_step(input loop_step_t st);
		drive_res_t r;
		int slot;
		longint err;
		longint dm;
		longint acc;
		longint val;
		slot = int'(st.ch) % pdc_pkg::LOOPS;
		r.loop_id = st.ch;
		if (st.op == pdc_pkg::CMD_CLEAR) begin
			integ[slot] = 0;
			last_meas[slot] = 0;
			r.drive = lo_bound;
		end else begin
			err = limit_diff(longint'(st.setp) - longint'(st.meas));
			dm = limit_diff(longint'(st.meas) - last_meas[slot]);
			acc = clamp_bounds(integ[slot] + longint'(ki_gain) * err);
			integ[slot] = acc;
			val = clamp_bounds(longint'(kp_gain) * err + acc - longint'(kd_gain) * dm);
			if (val < 0)
				val = 0;
			r.drive = pdc_pkg::OUT_W'(val >>> pdc_pkg::GAIN_FRAC_BITS);
			last_meas[slot] = longint'(st.meas);
		end
		return r;
	endfunction

	// Sender: offers queued steps and predicts each one at its transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				drive_q.push_back(pid_step(cur_step));
				n_accepted++;
				if (cur_step.op == pdc_pkg::CMD_CLEAR)
					n_clears++;
			end else if (in_valid) begin
				n_stalls_in++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (step_q.size() > 0) begin
					cur_step = step_q.pop_front();
					cmd <= cur_step.op;
					channel <= cur_step.ch;
					measured <= cur_step.meas;
					setpoint <= cur_step.setp;
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 6) == 0)
						gap_left = $urandom_range(1, 8);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every result transfer against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (drive_q.size() == 0) begin
					if (n_fail < 10)
						$display("result with nothing predicted: drive %0d loop_id %0d",
							drive, loop_id);
					n_fail++;
				end else begin
					want = drive_q.pop_front();
					if (want.drive !== drive || want.loop_id !== loop_id) begin
						if (n_fail < 10)
							$display("mismatch at result %0d: drive exp %0d got %0d, loop_id exp %0d got %0d",
								n_results, want.drive, drive, want.loop_id, loop_id);
						n_fail++;
					end
				end
				// Long hold-offs let the pipeline fill until the input stalls.
				if (n_results == 300 || n_results == 650)
					hold_left = 48;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("[pid_drive_controller] ERROR");
			$finish;
		end
	end

	task automatic push_step(input logic op, input logic ch, input int m, input int s);
		loop_step_t st;
		st.op = op;
		st.ch = ch;
		st.meas = pdc_pkg::MEAS_WIDTH'(m);
		st.setp = pdc_pkg::MEAS_WIDTH'(s);
		step_q.push_back(st);
		n_queued++;
	endtask

	task automatic wait_idle();
		while (n_accepted != n_queued || drive_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input pdc_pkg::cfg_reg_t idx,
			input logic [pdc_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pdc_pkg::REG_KP: kp_gain = val;
			pdc_pkg::REG_KI: ki_gain = val;
			pdc_pkg::REG_KD: kd_gain = val;
			pdc_pkg::REG_OUT_MIN: lo_bound = val[pdc_pkg::OUT_W-1:0];
			pdc_pkg::REG_OUT_MAX: hi_bound = val[pdc_pkg::OUT_W-1:0];
			default: ;
		endcase
		n_cfg_writes++;
	endtask

	task automatic write_all(input logic [pdc_pkg::CFG_W-1:0] p,
			input logic [pdc_pkg::CFG_W-1:0] i,
			input logic [pdc_pkg::CFG_W-1:0] d, input int lo, input int hi);
		wait_idle();
		write_reg(pdc_pkg::REG_KP, p);
		write_reg(pdc_pkg::REG_KI, i);
		write_reg(pdc_pkg::REG_KD, d);
		write_reg(pdc_pkg::REG_OUT_MIN, pdc_pkg::CFG_W'(lo));
		write_reg(pdc_pkg::REG_OUT_MAX, pdc_pkg::CFG_W'(hi));
	endtask

	function automatic logic [pdc_pkg::CFG_W-1:0] pick_gain();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h0;
			default: return pdc_pkg::CFG_W'($urandom_range(0, 8 << 16))
				- pdc_pkg::CFG_W'(4 << 16);
		endcase
	endfunction

	task automatic random_config();
		int lo;
		int hi;
		case ($urandom_range(0, 6))
			0: begin lo = 0; hi = 255; end
			1: begin lo = 255; hi = 0; end
			2: begin lo = $urandom_range(0, 255); hi = lo; end
			3: begin lo = $urandom_range(100, 255); hi = $urandom_range(0, 99); end
			default: begin lo = $urandom_range(0, 80); hi = $urandom_range(120, 255); end
		endcase
		write_all(pick_gain(), pick_gain(), pick_gain(), lo, hi);
	endtask

	// Mostly slow setpoint tracking per loop, with clears and full-range noise mixed in.
	task automatic random_steps(input int count);
		int ch;
		int sel;
		for (int i = 0; i < count; i++) begin
			ch = $urandom_range(0, 1);
			sel = $urandom_range(0, 99);
			if (sel < 6) begin
				push_step(pdc_pkg::CMD_CLEAR, ch[0], int'($urandom), int'($urandom));
				walk_meas[ch] = 0;
			end else if (sel < 16) begin
				push_step(pdc_pkg::CMD_COMPUTE, ch[0], int'($urandom), int'($urandom));
			end else begin
				if ($urandom_range(0, 15) == 0)
					walk_sp[ch] = int'($urandom_range(0, 500)) - 150;
				walk_meas[ch] += (walk_sp[ch] - walk_meas[ch]) / 4
					+ int'($urandom_range(0, 24)) - 12;
				push_step(pdc_pkg::CMD_COMPUTE, ch[0], walk_meas[ch], walk_sp[ch]);
			end
		end
	endtask

	initial begin
		for (int k = 0; k < pdc_pkg::LOOPS; k++) begin
			integ[k] = 0;
			last_meas[k] = 0;
		end
		walk_sp = '{200, 120};
		walk_meas = '{0, 0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: the integrator starts at zero, below the lower bound.
		push_step(pdc_pkg::CMD_COMPUTE, 1'b0, 0, 0);
		push_step(pdc_pkg::CMD_COMPUTE, 1'b1, 5, 10);

		write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 0, 255);
		push_step(pdc_pkg::CMD_COMPUTE, 1'b0, 0, 50);
		push_step(pdc_pkg::CMD_COMPUTE, 1'b0, 20, 50);
		push_step(pdc_pkg::CMD_COMPUTE, 1'b1, -8388608, 8388607);
		push_step(pdc_pkg::CMD_COMPUTE, 1'b1, 8388607, -8388608);
		push_step(pdc_pkg::CMD_CLEAR, 1'b1, 8388607, -8388608);
		push_step(pdc_pkg::CMD_CLEAR, 1'b0, 0, 0);
		push_step(pdc_pkg::CMD_COMPUTE, 1'b0, -1, 0);

		// Inverted bounds with extreme gains.
		write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 200, 50);
		push_step(pdc_pkg::CMD_COMPUTE, 1'b0, 0, 3);
		push_step(pdc_pkg::CMD_COMPUTE, 1'b1, 7, 7);
		push_step(pdc_pkg::CMD_CLEAR, 1'b1, 0, 0);
		push_step(pdc_pkg::CMD_COMPUTE, 1'b1, 4, -4);

		// Derivative alone, with large jumps of the measured value.
		write_all(32'h0, 32'h0, 32'h7FFF_FFFF, 0, 255);
		push_step(pdc_pkg::CMD_COMPUTE, 1'b0, -100, 0);
		push_step(pdc_pkg::CMD_COMPUTE, 1'b0, 8388607, 0);
		push_step(pdc_pkg::CMD_COMPUTE, 1'b1, -8388608, 0);
		push_step(pdc_pkg::CMD_COMPUTE, 1'b1, -8388608, 0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_config();
			if (ph == RANDOM_PHASES - 1)
				quiet = 1'b1;
			random_steps(STEPS_PER_PHASE);
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("covered %0d steps (%0d clears) over %0d register writes",
			n_accepted, n_clears, n_cfg_writes);
		$display("checked %0d results, %0d cycles with the input held off",
			n_results, n_stalls_in);
		if (n_fail == 0)
			$display("[pid_drive_controller] OK");
		else
			$display("[pid_drive_controller] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
design/pdc_pkg.sv
design/pdc_config.sv
design/pdc_state_mem.sv
design/pid_drive_controller.sv
tb/testbench.sv
